// ----- hw/rtl/ulf_pkg.sv -----
// package with shared types, constants and the latin fold table
`timescale 1ns / 1ps

package ulf_pkg;

    localparam logic [7:0] C_MASK_LEAD3 = 8'hE0;
    localparam logic [7:0] C_LEAD2      = 8'hC0;
    localparam logic [7:0] C_CONT       = 8'h80;
    localparam logic [7:0] C_MASK_CONT  = 8'hC0;
    localparam logic [7:0] C_MASK_LEAD4 = 8'hF0;
    localparam logic [7:0] C_LEAD3      = 8'hE0;
    localparam logic [6:0] C_QMARK      = 7'h3F;
    localparam logic [6:0] C_APOS       = 7'h27;
    localparam logic [6:0] C_NUL        = 7'h00;
    localparam logic [1:0] C_SKIP_SHORT = 2'd2;
    localparam logic [1:0] C_SKIP_LONG  = 2'd3;

    // one queued entry: one or two characters from a single input byte
    typedef struct packed {
        logic       has_second;
        logic [6:0] first;
        logic [6:0] second;
    } t_desc;

    typedef struct packed {
        logic       hit;
        logic [6:0] first;
        logic [6:0] second;
    } t_fold;

    function automatic t_fold fold_lookup(input logic [10:0] cp);
        t_fold f;
        f = '{hit: 1'b1, first: C_QMARK, second: C_NUL};
        unique case (cp)
            11'h0E0, 11'h0E1: begin f.first = 7'h61; f.second = C_APOS; end
            11'h0E2:          begin f.first = 7'h61; end
            11'h0E8, 11'h0E9: begin f.first = 7'h65; f.second = C_APOS; end
            11'h0EA:          begin f.first = 7'h65; end
            11'h0EC, 11'h0ED: begin f.first = 7'h69; f.second = C_APOS; end
            11'h0EE:          begin f.first = 7'h69; end
            11'h0F2, 11'h0F3: begin f.first = 7'h6F; f.second = C_APOS; end
            11'h0F4:          begin f.first = 7'h6F; end
            11'h0F9, 11'h0FA: begin f.first = 7'h75; f.second = C_APOS; end
            11'h0FB:          begin f.first = 7'h75; end
            11'h0E7:          begin f.first = 7'h63; end
            11'h0F1:          begin f.first = 7'h6E; end
            11'h0C0:          begin f.first = 7'h41; f.second = C_APOS; end
            11'h0C8, 11'h0C9: begin f.first = 7'h45; f.second = C_APOS; end
            11'h0CC:          begin f.first = 7'h49; f.second = C_APOS; end
            11'h0D2:          begin f.first = 7'h4F; f.second = C_APOS; end
            11'h0D9:          begin f.first = 7'h55; f.second = C_APOS; end
            default:          begin f.hit = 1'b0; end
        endcase
        return f;
    endfunction

endpackage

// ----- hw/rtl/ulf_if.sv -----
// valid/ready channel interfaces for input bytes and output characters
`timescale 1ns / 1ps

interface ulf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface ulf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ----- hw/rtl/ulf_front.sv -----
// front end: accepts bytes, tracks utf-8 state, classifies into queue entries
`timescale 1ns / 1ps

module ulf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ulf_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output ulf_pkg::t_desc o_desc
);
    import ulf_pkg::*;

    logic       r_lead_valid, n_lead_valid;
    logic [4:0] r_lead_payload, n_lead_payload;
    logic [1:0] r_skip_left, n_skip_left;
    logic       accept;
    logic       emit;
    t_desc      desc;
    t_fold      fold;
    logic [7:0] b;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign fold       = fold_lookup({r_lead_payload, b[5:0]});

    always_comb begin
        n_lead_valid   = r_lead_valid;
        n_lead_payload = r_lead_payload;
        n_skip_left    = r_skip_left;
        emit           = 1'b0;
        desc           = '{has_second: 1'b0, first: C_QMARK, second: C_NUL};
        priority if (b == 8'h00) begin
            emit           = 1'b1;
            desc.has_second = r_lead_valid;
            desc.first     = r_lead_valid ? C_QMARK : C_NUL;
            n_lead_valid   = 1'b0;
            n_lead_payload = '0;
            n_skip_left    = '0;
        end else if (r_skip_left != 2'd0) begin
            n_skip_left = r_skip_left - 2'd1;
        end else if (r_lead_valid) begin
            n_lead_valid   = 1'b0;
            n_lead_payload = '0;
            emit           = 1'b1;
            if ((b & C_MASK_CONT) == C_CONT) begin
                if (fold.hit) begin
                    desc.first      = fold.first;
                    desc.second     = fold.second;
                    desc.has_second = (fold.second != C_NUL);
                end
            end else begin
                n_skip_left = C_SKIP_SHORT;
            end
        end else if (b < C_CONT) begin
            emit       = 1'b1;
            desc.first = b[6:0];
        end else if ((b & C_MASK_LEAD3) == C_LEAD2) begin
            n_lead_valid   = 1'b1;
            n_lead_payload = b[4:0];
        end else begin
            emit        = 1'b1;
            n_skip_left = ((b & C_MASK_LEAD4) == C_LEAD3) ? C_SKIP_SHORT : C_SKIP_LONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_valid   <= 1'b0;
            r_lead_payload <= '0;
            r_skip_left    <= '0;
        end else if (accept) begin
            r_lead_valid   <= n_lead_valid;
            r_lead_payload <= n_lead_payload;
            r_skip_left    <= n_skip_left;
        end
    end

    assign o_push = accept && emit;
    assign o_desc = desc;

    a_lead_skip_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lead_valid && (r_skip_left != 2'd0)))
        else $error("lead held while skipping");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (b == 8'h00)) |=> (!r_lead_valid && (r_skip_left == 2'd0)))
        else $error("terminator did not clear state");

    a_lead_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_lead_valid && (r_skip_left == 2'd0)
            && ((b & C_MASK_LEAD3) == C_LEAD2)) |=> r_lead_valid)
        else $error("two-byte lead not held");
endmodule

// ----- hw/rtl/ulf_queue.sv -----
// short fifo of classified entries between front and back
`timescale 1ns / 1ps

module ulf_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ulf_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ulf_pkg::t_desc o_desc
);
    import ulf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_desc          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");
endmodule

// ----- hw/rtl/ulf_back.sv -----
// back end: expands queue entries into one character per transaction
`timescale 1ns / 1ps

module ulf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ulf_pkg::t_desc i_desc,
    output logic           o_pop,
    ulf_out_if.source      o_out
);
    import ulf_pkg::*;

    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       r_phase;
    logic       load;
    logic       is_last;

    assign load    = (!r_valid || o_out.ready) && i_q_valid;
    assign is_last = r_phase || !i_desc.has_second;
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !is_last;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= r_phase ? i_desc.second : i_desc.first;
            r_last <= is_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_char = r_char;
    assign o_out.run_last = r_last;

    a_phase_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> i_q_valid)
        else $error("second character pending without queue entry");

    a_phase_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_valid && !r_last))
        else $error("second phase without a first character shown");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_out.ready) |=> (r_valid && $stable(r_char) && $stable(r_last)))
        else $error("output register changed while stalled");
endmodule

// ----- hw/rtl/utf8_latin_fold_to_ascii.sv -----
// top level: utf-8 to ascii folder with decoupled front, queue and back
//
// usage:
//   i_in takes one utf-8 byte per transaction (in_byte); byte 0 ends a string.
//   o_out gives one ascii character per transaction (out_char) with run_last
//   set on the final character caused by an input byte. ascii bytes pass
//   through, two-byte latin letters fold to one or two characters, other
//   sequences give '?' and swallow their trailing bytes.
//   a byte that causes output is written into the queue and then loaded into
//   the output register. throughput: one byte per cycle in while the queue
//   is not full, and one character per cycle out while o_out.ready is high;
//   a byte that folds to two characters takes two output transactions, so the
//   sustained byte rate is set by the single output register. the
//   QUEUE_DEPTH-entry queue absorbs bursts between the sides.
//   reset: synchronous, active low; clears utf-8 state, queue and output.
//   stall: when o_out.ready is low the output register holds, the queue fills,
//   and i_in.ready drops once the queue is full.
`timescale 1ns / 1ps

module utf8_latin_fold_to_ascii #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ulf_in_if.sink    i_in,
    ulf_out_if.source o_out
);
    import ulf_pkg::*;

    logic  q_full;
    logic  push;
    logic  pop;
    logic  q_valid;
    t_desc push_desc;
    t_desc head_desc;

    ulf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    ulf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    ulf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_desc    (head_desc),
        .o_pop     (pop),
        .o_out     (o_out)
    );
endmodule
